FILE: sv/wwsm_pkg.sv
// ----------------------------------------------------------------------------
// wwsm_pkg
// Shared constants for the weighted window sum / maximum block.
// ----------------------------------------------------------------------------
package wwsm_pkg;

   // defaults for the top-level parameters
   localparam int WINDOW_MAX_DEF  = 256;
   localparam int SAMPLE_BITS_DEF = 24;

   // fixed widths of the accumulators and the length register
   localparam int WSUM_W = 48;   // weighted sum, wraps in two's complement
   localparam int PSUM_W = 40;   // plain sum, wraps in two's complement
   localparam int CFG_W  = 9;    // window length register

endpackage

FILE: sv/weighted_window_sum_max.sv
// ----------------------------------------------------------------------------
// weighted_window_sum_max
// Linearly weighted moving sum over the last L samples, with the running
// maximum of that sum over all full windows of the current sequence.
// ----------------------------------------------------------------------------
// Throughput is one item per clock unless the output is stalled. An item
// passes through four register stages on its way to the output register.
// The whole pipeline moves forward in any cycle in which the output
// register is empty or being taken, so req_tready follows rsp_tready
// through that one condition.
// The per-sample work is a constant-time recurrence: W' = W - P + x*L and
// P' = P - oldest + x once the window is full, W' = W + x*k and P' = P + x
// while it fills (k counting samples from 1). The sample ring buffer is a
// WINDOW_MAX-deep RAM, written with the new sample and read for the sample
// leaving the window in the same cycle the item is accepted (read-first, so
// a full-depth window still sees the old entry). The window length is taken
// from the register on the first sample of each sequence and held until the
// sample marked tlast; a register value of 0 acts as 1 and a value above
// WINDOW_MAX acts as WINDOW_MAX. After the tlast item the sums, the count,
// the ring pointer and the maximum are cleared. Before the window first
// fills, best_sum reads zero and weighted_sum carries the partial sum.
// Pipeline: input/RAM read -> multiply -> accumulate -> maximum/output.
// ----------------------------------------------------------------------------
module weighted_window_sum_max #(
   parameter int WINDOW_MAX  = wwsm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = wwsm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // window length register
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wwsm_pkg::CFG_W-1:0]            csr_data,     // window_length

   // sample stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,    // sample
   input  logic                                  req_tlast,    // is_last

   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [2*wwsm_pkg::WSUM_W-1:0]         rsp_tdata,    // weighted_sum, best_sum
   output logic                                  rsp_tuser,    // window_full
   output logic                                  rsp_tlast     // last_out
);

   localparam int WSUM_W = wwsm_pkg::WSUM_W;
   localparam int PSUM_W = wwsm_pkg::PSUM_W;
   localparam int CFG_W  = wwsm_pkg::CFG_W;
   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int PROD_W = SAMPLE_BITS + LEN_W + 1;

   // ---------------------------------------------------------------- control
   logic                    advance;
   logic                    req_acc;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign req_acc    = req_tvalid && advance;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- register
   logic [CFG_W-1:0]        csr_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= CFG_W'(1);
      end else if (csr_valid) begin
         csr_len_ff <= csr_data;
      end
   end

   // clamp into 1..WINDOW_MAX
   logic [LEN_W-1:0]        len_eff;

   always_comb begin
      if (csr_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (CMP_W'(csr_len_ff) > CMP_W'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = LEN_W'(csr_len_ff);
      end
   end

   // ------------------------------------------------------- front end state
   logic [LEN_W-1:0]        count_ff, count_in;
   logic [LEN_W-1:0]        len_act_ff, len_cur;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [LEN_W:0]          count_p1;
   logic                    was_full_c, now_full_c;
   logic [LEN_W-1:0]        weight_c;
   logic [LEN_W:0]          ptr_x, len_x, rd_wide;
   logic [PTR_W-1:0]        rd_addr;

   always_comb begin
      // length latched on the first sample of a sequence
      len_cur    = (count_ff == '0) ? len_eff : len_act_ff;
      was_full_c = count_ff >= len_cur;
      count_p1   = {1'b0, count_ff} + (LEN_W+1)'(1);
      now_full_c = was_full_c || (count_p1 == {1'b0, len_cur});
      weight_c   = was_full_c ? len_cur : count_p1[LEN_W-1:0];

      // address of the sample leaving the window, modulo WINDOW_MAX
      ptr_x   = (LEN_W+1)'(ptr_ff);
      len_x   = {1'b0, len_cur};
      rd_wide = (ptr_x >= len_x) ? ptr_x - len_x
                                 : ptr_x + (LEN_W+1)'(WINDOW_MAX) - len_x;
      rd_addr = rd_wide[PTR_W-1:0];

      if (req_tlast) begin
         count_in = '0;
         ptr_in   = '0;
      end else begin
         count_in = was_full_c ? count_ff : count_p1[LEN_W-1:0];
         ptr_in   = (ptr_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ptr_ff     <= '0;
         len_act_ff <= LEN_W'(1);
      end else if (req_acc) begin
         count_ff   <= count_in;
         ptr_ff     <= ptr_in;
         len_act_ff <= len_cur;
      end
   end

   // ------------------------------------------------------------ ring buffer
   logic [SAMPLE_BITS-1:0]  ring_mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         ring_mem[ptr_ff] <= req_tdata[SAMPLE_BITS-1:0];
         rd_data_ff       <= ring_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic                    s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic                    s1_last_ff, s1_was_ff, s1_now_ff;
   logic [LEN_W-1:0]        s1_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_x_ff      <= req_tdata[SAMPLE_BITS-1:0];
         s1_last_ff   <= req_tlast;
         s1_was_ff    <= was_full_c;
         s1_now_ff    <= now_full_c;
         s1_weight_ff <= weight_c;
      end
   end

   // ---------------------------------------------------- stage 2: multiply
   logic signed [PROD_W-1:0] prod_c;
   logic                    s2_valid_ff;
   logic signed [WSUM_W-1:0] s2_prod_ff;
   logic signed [SAMPLE_BITS-1:0] s2_x_ff, s2_old_ff;
   logic                    s2_last_ff, s2_was_ff, s2_now_ff;

   assign prod_c = s1_x_ff * $signed({1'b0, s1_weight_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_prod_ff <= WSUM_W'(prod_c);
         s2_x_ff    <= s1_x_ff;
         s2_old_ff  <= rd_data_ff;
         s2_last_ff <= s1_last_ff;
         s2_was_ff  <= s1_was_ff;
         s2_now_ff  <= s1_now_ff;
      end
   end

   // -------------------------------------------------- stage 3: accumulate
   logic signed [WSUM_W-1:0] acc_w_ff, acc_w_in;
   logic signed [PSUM_W-1:0] acc_p_ff, acc_p_in;
   logic                    s3_valid_ff;
   logic signed [WSUM_W-1:0] s3_wsum_ff;
   logic                    s3_last_ff, s3_was_ff, s3_now_ff;

   always_comb begin
      if (s2_was_ff) begin
         acc_w_in = acc_w_ff - WSUM_W'(acc_p_ff) + s2_prod_ff;
         acc_p_in = acc_p_ff - PSUM_W'(s2_old_ff) + PSUM_W'(s2_x_ff);
      end else begin
         acc_w_in = acc_w_ff + s2_prod_ff;
         acc_p_in = acc_p_ff + PSUM_W'(s2_x_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         acc_w_ff    <= '0;
         acc_p_ff    <= '0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            acc_w_ff <= s2_last_ff ? '0 : acc_w_in;
            acc_p_ff <= s2_last_ff ? '0 : acc_p_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_wsum_ff <= acc_w_in;
         s3_last_ff <= s2_last_ff;
         s3_was_ff  <= s2_was_ff;
         s3_now_ff  <= s2_now_ff;
      end
   end

   // -------------------------------------------- stage 4: maximum / output
   logic signed [WSUM_W-1:0] best_ff, best_in;
   logic                    rsp_valid_ff;
   logic signed [WSUM_W-1:0] rsp_wsum_ff, rsp_best_ff;
   logic                    rsp_full_ff, rsp_last_ff;

   // first full window takes the sum whatever its sign
   assign best_in = (s3_now_ff && (!s3_was_ff || (s3_wsum_ff > best_ff))) ? s3_wsum_ff
                                                                           : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         best_ff      <= '0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            best_ff <= s3_last_ff ? '0 : best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_wsum_ff <= s3_wsum_ff;
         rsp_best_ff <= best_in;
         rsp_full_ff <= s3_now_ff;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_best_ff, rsp_wsum_ff};
   assign rsp_tuser  = rsp_full_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   a_len_range : assert property (@(posedge clock) disable iff (reset)
      (len_act_ff != '0) && (len_act_ff <= LEN_W'(WINDOW_MAX)))
      else $error("latched window length out of range");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (count_ff <= len_act_ff))
      else $error("sample count beyond window length");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> ((count_ff == '0) && (ptr_ff == '0)))
      else $error("sequence state not cleared after last item");

   a_best_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_full_ff) |-> (rsp_best_ff == '0))
      else $error("maximum non-zero before first full window");

endmodule

FILE: sim/weighted_window_sum_max_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_window_sum_max_test
// Self-checking bench for the weighted window sum / maximum block. A local
// predictor tracks the weighted and plain sums, the sample ring and the
// running maximum. Each accepted sample queues one expected result, which the
// checker compares field by field against the result stream. Directed items
// cover the field extremes, the length clamping, length latching and a
// negative first window. Random phases then sweep the window length, with
// random idle cycles on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module weighted_window_sum_max_test;

   localparam int WIN_MAX    = wwsm_pkg::WINDOW_MAX_DEF;
   localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
   localparam int TAIL_CYCLES = 8;      // pipeline is four registers deep
   localparam int PRINT_CAP  = 60;

   localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

   // one expected result item
   typedef struct packed {
      logic signed [wwsm_pkg::WSUM_W-1:0] wsum;
      logic signed [wwsm_pkg::WSUM_W-1:0] best;
      logic                               full;
      logic                               last;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [wwsm_pkg::CFG_W-1:0] csr_data   = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [23:0]                req_tdata  = '0;   // sample
   logic                       req_tlast  = 1'b0; // is_last
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [95:0]                rsp_tdata;         // weighted_sum, best_sum
   logic                       rsp_tuser;         // window_full
   logic                       rsp_tlast;         // last_out

   weighted_window_sum_max u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor state, reset values
   // ---------------------------------------------------------------------
   logic [wwsm_pkg::CFG_W-1:0]         window_cfg = 9'd1;  // register as written
   int                                 run_len    = 1;     // length latched for the sequence
   logic signed [wwsm_pkg::WSUM_W-1:0] wsum       = '0;
   logic signed [wwsm_pkg::PSUM_W-1:0] psum       = '0;
   int                                 fill_count = 0;
   int                                 ring_wr    = 0;
   logic signed [wwsm_pkg::WSUM_W-1:0] peak       = '0;
   logic signed [23:0]                 ring_mem [0:WIN_MAX-1] = '{default: '0};

   window_result_type pending_results[$];
   window_result_type want_r;

   int  sent_items  = 0;
   int  fail_count  = 0;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  quiet_mode  = 1'b0;   // no idling on either side while set

   function automatic int clamp_length(input logic [wwsm_pkg::CFG_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > WIN_MAX)
         return WIN_MAX;
      return int'(v);
   endfunction

   // Works out the result for one accepted sample and queues it.
   function void predict_window(input logic signed [23:0] x, input logic last);
      int                len_now;
      bit                was_full;
      int                old_idx;
      longint            xl;
      window_result_type r;
      if (fill_count == 0)
         run_len = clamp_length(window_cfg);
      len_now  = run_len;
      xl       = x;
      was_full = (fill_count >= len_now);
      if (was_full) begin
         // the oldest sample drops out; every other weight falls by one
         old_idx = (ring_wr - len_now + WIN_MAX) % WIN_MAX;
         wsum    = wsum - psum + xl * len_now;
         psum    = psum - ring_mem[old_idx] + x;
      end else begin
         wsum = wsum + xl * (fill_count + 1);
         psum = psum + x;
         fill_count++;
      end
      ring_mem[ring_wr] = x;
      ring_wr = (ring_wr + 1) % WIN_MAX;
      // first full window seeds the maximum whatever its sign
      if (fill_count >= len_now && (!was_full || wsum > peak))
         peak = wsum;
      r.wsum = wsum;
      r.best = peak;
      r.full = (fill_count >= len_now);
      r.last = last;
      pending_results.push_back(r);
      if (last) begin
         wsum       = '0;
         psum       = '0;
         fill_count = 0;
         ring_wr    = 0;
         peak       = '0;
      end
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 15))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return 24'sd0;
         default: return 24'($urandom());
      endcase
   endfunction

   // small lengths dominate; the clamped values and full depth now and then
   function automatic logic [wwsm_pkg::CFG_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 9'($urandom_range(1, 4));
      if (r < 70) return 9'($urandom_range(5, 16));
      if (r < 80) return 9'($urandom_range(17, 40));
      if (r < 86) return 9'd0;
      if (r < 92) return 9'($urandom_range(41, 255));
      if (r < 96) return 9'd256;
      return 9'($urandom_range(257, 511));
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      if (fail_count < PRINT_CAP)
         $display("MISMATCH %s: got %h, want %h (result %0d)", what, got, want,
                  sent_items - pending_results.size());
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // result checker, sampled at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata[47:0], '0);
         end else begin
            want_r = pending_results.pop_front();
            if (rsp_tdata[47:0] !== want_r.wsum)
               report_mismatch("weighted_sum", rsp_tdata[47:0], want_r.wsum);
            if (rsp_tdata[95:48] !== want_r.best)
               report_mismatch("best_sum", rsp_tdata[95:48], want_r.best);
            if (rsp_tuser !== want_r.full)
               report_mismatch("window_full", 48'(rsp_tuser), 48'(want_r.full));
            if (rsp_tlast !== want_r.last)
               report_mismatch("last_out", 48'(rsp_tlast), 48'(want_r.last));
         end
      end
   end

   // output back-pressure: one assignment per falling edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 5) == 0)
            stall_left = (pick_gap() == 0) ? 1 : pick_gap();
      end
   end

   // watchdog: ends the run if nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // shared drivers
   // ---------------------------------------------------------------------
   // Sends one sample; valid stays high when the next item follows at once.
   task automatic send_sample(input logic signed [23:0] x, input logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_window(x, last);
      sent_items++;
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_window_length(input logic [wwsm_pkg::CFG_W-1:0] v);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      window_cfg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // n random samples, the last one marked; may rewrite the length midway
   task automatic send_sequence(input int n, input bit allow_rewrite);
      for (int i = 0; i < n; i++) begin
         if (allow_rewrite && i > 0 && $urandom_range(0, 39) == 0)
            write_window_length(pick_length());
         send_sample(rand_sample(), i == n - 1);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // reset length of one: the output just follows the sample
   task automatic test_reset_length();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(24'sd0, 1'b1);
   endtask

   // first full window is negative and still becomes the maximum
   task automatic test_negative_first_window();
      write_window_length(9'd2);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(-24'sd1, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   task automatic test_sample_extremes();
      write_window_length(9'd3);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(-24'sd1, 1'b1);
   endtask

   // zero acts as one, anything above the depth acts as the depth
   task automatic test_length_clamp();
      write_window_length(9'd0);
      send_sample(24'sd5, 1'b0);
      send_sample(-24'sd5, 1'b1);
      write_window_length(9'd511);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(24'sd7, 1'b1);
   endtask

   // a write mid-sequence only takes hold at the next sequence
   task automatic test_length_latch();
      write_window_length(9'd4);
      send_sample(24'sd1, 1'b0);
      send_sample(24'sd2, 1'b0);
      write_window_length(9'd2);
      send_sample(24'sd3, 1'b0);
      send_sample(24'sd4, 1'b0);
      send_sample(24'sd5, 1'b1);
      send_sample(24'sd6, 1'b0);
      send_sample(24'sd7, 1'b1);
   endtask

   // full-depth ring, wrapping; then a clamped value of the same depth
   task automatic test_full_depth();
      write_window_length(9'd256);
      quiet_mode = ($urandom_range(0, 1) == 0);
      send_sequence(300, 1'b0);
      write_window_length(9'd257);
      quiet_mode = ($urandom_range(0, 1) == 0);
      send_sequence(262, 1'b0);
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_phases();
      int                         target;
      int                         seqs;
      int                         e;
      int                         n;
      logic [wwsm_pkg::CFG_W-1:0] v;
      target = sent_items + 890;
      while (sent_items < target) begin
         v = pick_length();
         write_window_length(v);
         e = clamp_length(v);
         quiet_mode = ($urandom_range(0, 3) == 0);
         seqs = (e > 40) ? 1 : $urandom_range(2, 6);
         repeat (seqs) begin
            // long windows get only slightly longer sequences
            n = (e > 40) ? $urandom_range(1, e + 16) : $urandom_range(1, 3 * e + 8);
            send_sequence(n, 1'b1);
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_length();
      test_negative_first_window();
      test_sample_extremes();
      test_length_clamp();
      test_length_latch();
      test_full_depth();
      test_random_phases();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
sv/wwsm_pkg.sv
sv/weighted_window_sum_max.sv
sim/weighted_window_sum_max_test.sv
